// ===== src/tcrs_pkg.sv =====
package tcrs_pkg;

    // curve table resolution
    localparam int CURVE_INDEX_BITS = 12;
    localparam int CURVE_TOP        = 255 << (CURVE_INDEX_BITS - 8);
    localparam int LUMA_SHIFT       = 24 - CURVE_INDEX_BITS;
    localparam int BIG_W            = 400;

    // luminance weights, q16, summing to one
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    // register indexes
    localparam logic [1:0] CFG_SRC_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_DST_LAYOUT   = 2'd1;
    localparam logic [1:0] CFG_SRGB_SOURCE  = 2'd2;

    // target layouts
    localparam logic [1:0] LAYOUT_ONE  = 2'd0;
    localparam logic [1:0] LAYOUT_TWO  = 2'd1;
    localparam logic [1:0] LAYOUT_FOUR = 2'd2;
    localparam logic [1:0] LAYOUT_NONE = 2'd3;

    typedef logic [CURVE_INDEX_BITS-1:0] t_cidx;
    typedef logic [255:0][CURVE_INDEX_BITS-1:0] t_thr_tab;
    typedef logic [255:0][7:0] t_byte_tab;

    typedef struct packed {
        logic [2:0] src_channels;
        logic [1:0] dst_layout;
        logic       srgb_source;
    } t_cfg;

    // pixel as it travels down the pipe
    typedef struct packed {
        logic [7:0] o0;
        logic [7:0] o1;
        logic [7:0] o2;
        logic [7:0] o3;
        logic       use_curve;
        t_cidx      idx;
    } t_side;

    // exact test 255*((x+0.055)/1.055)^2.4 >= k-0.5, both sides to the fifth power
    function automatic logic pow_reaches(longint unsigned i, longint unsigned k);
        logic [BIG_W-1:0] a;
        logic [BIG_W-1:0] b;
        a = BIG_W'(1);
        b = BIG_W'(1);
        for (int n = 0; n < 5; n++) begin
            a = a * BIG_W'(510);
            b = b * BIG_W'(2 * k - 1);
        end
        for (int n = 0; n < 12; n++) begin
            a = a * BIG_W'(1000 * i + 55 * CURVE_TOP);
            b = b * BIG_W'(1055 * CURVE_TOP);
        end
        return a >= b;
    endfunction

    // true when curve entry i is at least k (k from 1 to 255)
    function automatic logic curve_ge(longint unsigned i, longint unsigned k);
        longint unsigned lin;
        lin = (51000 * i + 1292 * CURVE_TOP) / (2584 * CURVE_TOP);
        if (i * 100000 <= 4045 * CURVE_TOP) begin
            return lin >= k;
        end
        return pow_reaches(i, k);
    endfunction

    // first curve index that reaches each output code
    function automatic t_thr_tab build_thr();
        t_thr_tab        t;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        t = '0;
        for (int k = 1; k < 256; k++) begin
            lo = 0;
            hi = CURVE_TOP;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (curve_ge(mid, longint'(k))) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            t[k] = CURVE_INDEX_BITS'(lo);
        end
        return t;
    endfunction

    // curve at byte positions, counted from the thresholds
    function automatic t_byte_tab build_byte(t_thr_tab thr);
        t_byte_tab t;
        int        cnt;
        for (int b = 0; b < 256; b++) begin
            cnt = 0;
            for (int k = 1; k < 256; k++) begin
                if (int'(thr[k]) <= (b << (CURVE_INDEX_BITS - 8))) begin
                    cnt++;
                end
            end
            t[b] = 8'(cnt);
        end
        return t;
    endfunction

    localparam t_thr_tab  CURVE_THR  = build_thr();
    localparam t_byte_tab CURVE_BYTE = build_byte(CURVE_THR);

endpackage

// ===== src/texel_channel_repack_srgb_top.sv =====
// texel channel repacker: one 8-bit pixel of 1 to 4 source channels in, one pixel of 1, 2
// or 4 channels out, with optional srgb-to-linear conversion of the colour channels (not
// in the two-channel layout) and luminance reduction for the one-channel layout.
// a request is taken on every clock at which start is high; busy is never raised, so
// one pixel per cycle is sustained. each result is flagged by o_valid for one cycle and
// passes two front stages (weights, then sum and byte curve lookups), eight stages that
// resolve the luminance curve code one bit at a time against a threshold table, and the
// output register. the receiver cannot stall and must take every result as it comes.
// with layout code three no result is produced. configuration writes are always
// accepted and should only be made while no request is in flight.
module texel_channel_repack_srgb_top import tcrs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_in_c0,
    input  logic [7:0] i_in_c1,
    input  logic [7:0] i_in_c2,
    input  logic [7:0] i_in_c3,
    output logic       o_valid,
    output logic [7:0] o_out_c0,
    output logic [7:0] o_out_c1,
    output logic [7:0] o_out_c2,
    output logic [7:0] o_out_c3,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [2:0] i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_channels <= 3'd4;
            r_cfg.dst_layout   <= LAYOUT_FOUR;
            r_cfg.srgb_source  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SRC_CHANNELS: r_cfg.src_channels <= i_cfg_data;
                CFG_DST_LAYOUT:   r_cfg.dst_layout   <= i_cfg_data[1:0];
                CFG_SRGB_SOURCE:  r_cfg.srgb_source  <= i_cfg_data[0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // the pipe never backs up, so requests are always welcome
    assign busy = 1'b0;

    // a request with no valid layout simply never enters the pipe
    logic n_take;
    assign n_take = start && !busy && (r_cfg.dst_layout != LAYOUT_NONE);

    logic  w_front_v;
    t_side w_front_side;

    tcrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_take),
        .i_cfg   (r_cfg),
        .i_c0    (i_in_c0),
        .i_c1    (i_in_c1),
        .i_c2    (i_in_c2),
        .i_c3    (i_in_c3),
        .o_valid (w_front_v),
        .o_side  (w_front_side)
    );

    logic       w_srch_v;
    t_side      w_srch_side;
    logic [7:0] w_srch_code;

    tcrs_curve_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_v),
        .i_side  (w_front_side),
        .o_valid (w_srch_v),
        .o_side  (w_srch_side),
        .o_code  (w_srch_code)
    );

    // output register: luminance through the curve takes the searched code
    logic       r_out_v;
    logic [7:0] r_c0, r_c1, r_c2, r_c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_srch_v;
        end
        r_c0 <= w_srch_side.use_curve ? w_srch_code : w_srch_side.o0;
        r_c1 <= w_srch_side.o1;
        r_c2 <= w_srch_side.o2;
        r_c3 <= w_srch_side.o3;
    end

    assign o_valid  = r_out_v;
    assign o_out_c0 = r_c0;
    assign o_out_c1 = r_c1;
    assign o_out_c2 = r_c2;
    assign o_out_c3 = r_c3;

endmodule

// ===== src/tcrs_front.sv =====
module tcrs_front import tcrs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_c0,
    input  logic [7:0] i_c1,
    input  logic [7:0] i_c2,
    input  logic [7:0] i_c3,
    output logic       o_valid,
    output t_side      o_side
);

    // stage one: weights applied, channels chosen
    logic        r_v1;
    logic [23:0] r_p0, r_p1, r_p2;
    logic [7:0]  r_r, r_g, r_b, r_a;
    logic [1:0]  r_layout;
    logic        r_srgb, r_ge3, r_eq2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_p0     <= 24'(W_RED) * {16'd0, i_c0};
        r_p1     <= 24'(W_GREEN) * {16'd0, i_c1};
        r_p2     <= 24'(W_BLUE) * {16'd0, i_c2};
        r_r      <= i_c0;
        r_g      <= (i_cfg.src_channels >= 3'd2) ? i_c1 : i_c0;
        r_b      <= (i_cfg.src_channels >= 3'd3) ? i_c2 : i_c0;
        r_a      <= (i_cfg.src_channels >= 3'd4) ? i_c3 : 8'd255;
        r_layout <= i_cfg.dst_layout;
        r_srgb   <= i_cfg.srgb_source;
        r_ge3    <= (i_cfg.src_channels >= 3'd3);
        r_eq2    <= (i_cfg.src_channels == 3'd2);
    end

    // stage two: luminance sum, byte curve lookups, layout
    logic [23:0] n_sum, n_lin_r, n_idx_r;
    logic [7:0]  n_cr, n_cg, n_cb;
    t_side       n_side;
    logic        r_v2;
    t_side       r_side;

    always_comb begin
        n_sum   = r_p0 + r_p1 + r_p2;
        n_lin_r = n_sum + 24'd32768;
        n_idx_r = n_sum + 24'(1 << (LUMA_SHIFT - 1));
        n_cr    = CURVE_BYTE[r_r];
        n_cg    = CURVE_BYTE[r_g];
        n_cb    = CURVE_BYTE[r_b];
        n_side           = '0;
        n_side.idx       = n_idx_r[23:LUMA_SHIFT];
        case (r_layout)
            LAYOUT_ONE: begin
                if (r_ge3) begin
                    n_side.use_curve = r_srgb;
                    n_side.o0        = n_lin_r[23:16];
                end else begin
                    n_side.o0 = r_srgb ? n_cr : r_r;
                end
            end
            LAYOUT_TWO: begin
                n_side.o0 = r_r;
                n_side.o1 = r_g;
            end
            LAYOUT_FOUR: begin
                n_side.o0 = r_srgb ? n_cr : r_r;
                n_side.o1 = r_srgb ? n_cg : r_g;
                n_side.o2 = r_srgb ? n_cb : (r_eq2 ? 8'd0 : r_b);
                n_side.o3 = r_a;
            end
            default: begin
                n_side.o0 = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_side <= n_side;
    end

    assign o_valid = r_v2;
    assign o_side  = r_side;

endmodule

// ===== src/tcrs_curve_search.sv =====
module tcrs_curve_search import tcrs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_side      i_side,
    output logic       o_valid,
    output t_side      o_side,
    output logic [7:0] o_code
);

    // one output bit per stage, msb first, against the threshold table
    logic       w_v    [0:8];
    t_side      w_side [0:8];
    logic [7:0] w_acc  [0:8];

    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;
    assign w_acc[0]  = 8'd0;

    for (genvar j = 0; j < 8; j++) begin : g_lvl
        logic [7:0] n_cand;
        logic [7:0] n_acc;
        logic       r_v;
        t_side      r_side;
        logic [7:0] r_acc;

        always_comb begin
            n_cand = w_acc[j] | (8'd1 << (7 - j));
            n_acc  = (CURVE_THR[n_cand] <= w_side[j].idx) ? n_cand : w_acc[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[j];
            end
            r_side <= w_side[j];
            r_acc  <= n_acc;
        end

        assign w_v[j+1]    = r_v;
        assign w_side[j+1] = r_side;
        assign w_acc[j+1]  = r_acc;
    end

    assign o_valid = w_v[8];
    assign o_side  = w_side[8];
    assign o_code  = w_acc[8];

endmodule

// ===== tb/tb_texel_channel_repack_srgb_top.sv =====
module tb_texel_channel_repack_srgb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcrs_pkg::*;

    // pipeline depth from request to result, plus margin before touching registers
    localparam int PIPE_LATENCY = 11;
    localparam int SETTLE       = PIPE_LATENCY + 5;
    localparam int N_ITEMS      = 1700;
    localparam int STALL_LIMIT  = 1000;
    localparam int N_DIR        = 25;

    // index past the last register, writes to it must change nothing
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // one texel, byte j is channel j
    typedef logic [3:0][7:0] t_pix;

    // wide enough for (1055 * 4080)^12 * 510^5
    typedef logic [335:0] t_wide;

    // one stimulus row: settings, texel and, where typed in, the expected texel
    typedef struct packed {
        logic [2:0] nsrc;
        logic [1:0] layout;
        logic       srgb;
        t_pix       px;
        logic       typed;
        logic       has_res;
        t_pix       want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] i_in_c0 = '0;
    logic [7:0] i_in_c1 = '0;
    logic [7:0] i_in_c2 = '0;
    logic [7:0] i_in_c3 = '0;
    logic       o_valid;
    logic [7:0] o_out_c0;
    logic [7:0] o_out_c1;
    logic [7:0] o_out_c2;
    logic [7:0] o_out_c3;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [2:0] i_cfg_data = '0;

    // register copies, tracking what the block holds after each accepted write
    logic [2:0] cfg_src    = 3'd4;
    logic [1:0] cfg_layout = LAYOUT_FOUR;
    logic       cfg_srgb   = 1'b0;

    // srgb-to-linear curve, one entry per curve index
    logic [7:0] lin_curve [0:CURVE_TOP];

    // expected texels in request order
    t_pix want_texels [$];

    // row riding along with the request currently on the ports
    t_row cur_req = '0;

    int n_fail    = 0;
    int stall_cnt = 0;

    // pixels are written {c3, c2, c1, c0}; typed rows carry the texel read off by hand
    t_row dir_rows [N_DIR] = '{
        // reset settings: four channels in, four out, linear
        '{3'd4, LAYOUT_FOUR, 1'b0, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
        '{3'd4, LAYOUT_FOUR, 1'b0, 32'hffffffff, 1'b1, 1'b1, 32'hffffffff},
        '{3'd4, LAYOUT_FOUR, 1'b0, 32'h78563412, 1'b1, 1'b1, 32'h78563412},
        // luminance, weights sum to one so white stays white, alpha ignored
        '{3'd4, LAYOUT_ONE,  1'b0, 32'h00ffffff, 1'b1, 1'b1, 32'h000000ff},
        '{3'd4, LAYOUT_ONE,  1'b0, 32'hff000000, 1'b1, 1'b1, 32'h00000000},
        '{3'd3, LAYOUT_ONE,  1'b0, 32'h55c04080, 1'b0, 1'b0, 32'h00000000},
        // too few channels for luminance: channel 0 passes through
        '{3'd2, LAYOUT_ONE,  1'b0, 32'h443322a5, 1'b1, 1'b1, 32'h000000a5},
        // two-channel target, grey source repeats, never converted
        '{3'd1, LAYOUT_TWO,  1'b0, 32'h00ee993c, 1'b1, 1'b1, 32'h00003c3c},
        '{3'd2, LAYOUT_TWO,  1'b0, 32'h00ee993c, 1'b1, 1'b1, 32'h0000993c},
        '{3'd4, LAYOUT_TWO,  1'b1, 32'h00ee993c, 1'b1, 1'b1, 32'h0000993c},
        // four-channel target: blue forced to zero for a two-channel linear source
        '{3'd2, LAYOUT_FOUR, 1'b0, 32'h44332211, 1'b1, 1'b1, 32'hff002211},
        '{3'd1, LAYOUT_FOUR, 1'b0, 32'h4433227e, 1'b1, 1'b1, 32'hff7e7e7e},
        '{3'd3, LAYOUT_FOUR, 1'b0, 32'h44332211, 1'b1, 1'b1, 32'hff332211},
        '{3'd2, LAYOUT_FOUR, 1'b1, 32'h44332211, 1'b0, 1'b0, 32'h00000000},
        // srgb ends of the curve, alpha untouched
        '{3'd4, LAYOUT_FOUR, 1'b1, 32'h9a00ff00, 1'b1, 1'b1, 32'h9a00ff00},
        '{3'd4, LAYOUT_FOUR, 1'b1, 32'h0180280a, 1'b0, 1'b0, 32'h00000000},
        '{3'd1, LAYOUT_ONE,  1'b1, 32'h0000000b, 1'b0, 1'b0, 32'h00000000},
        '{3'd4, LAYOUT_ONE,  1'b1, 32'h00ffffff, 1'b1, 1'b1, 32'h000000ff},
        '{3'd4, LAYOUT_ONE,  1'b1, 32'h00f08010, 1'b0, 1'b0, 32'h00000000},
        // source counts out of range clamp to one and four
        '{3'd0, LAYOUT_FOUR, 1'b0, 32'h88776655, 1'b1, 1'b1, 32'hff555555},
        '{3'd7, LAYOUT_FOUR, 1'b0, 32'h88776655, 1'b1, 1'b1, 32'h88776655},
        '{3'd5, LAYOUT_ONE,  1'b0, 32'h0010e0f0, 1'b0, 1'b0, 32'h00000000},
        // layout code three gives nothing back
        '{3'd4, LAYOUT_NONE, 1'b0, 32'h12345678, 1'b1, 1'b0, 32'h00000000},
        '{3'd4, LAYOUT_NONE, 1'b1, 32'hdeadbeef, 1'b1, 1'b0, 32'h00000000},
        '{3'd6, LAYOUT_TWO,  1'b1, 32'h0000fe01, 1'b1, 1'b1, 32'h0000fe01}
    };

    texel_channel_repack_srgb_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in_c0     (i_in_c0),
        .i_in_c1     (i_in_c1),
        .i_in_c2     (i_in_c2),
        .i_in_c3     (i_in_c3),
        .o_valid     (o_valid),
        .o_out_c0    (o_out_c0),
        .o_out_c1    (o_out_c1),
        .o_out_c2    (o_out_c2),
        .o_out_c3    (o_out_c3),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // fill the curve: linear segment by exact division, power segment by comparing
    // 255*((x+0.055)/1.055)^2.4 against each code's rounding point, both sides to the
    // fifth power so everything stays in integers; the code only ever climbs with i
    task automatic build_lin_curve();
        t_wide rhs [1:255];
        t_wide scale;
        t_wide lhs;
        t_wide p5;
        int    code;
        scale = t_wide'(1);
        for (int n = 0; n < 12; n++) begin
            scale = scale * t_wide'(1055 * CURVE_TOP);
        end
        for (int k = 1; k < 256; k++) begin
            p5 = t_wide'(1);
            for (int n = 0; n < 5; n++) begin
                p5 = p5 * t_wide'(2 * k - 1);
            end
            rhs[k] = p5 * scale;
        end
        code = 0;
        for (int i = 0; i <= CURVE_TOP; i++) begin
            if (longint'(i) * 100000 <= 4045 * longint'(CURVE_TOP)) begin
                code = int'((51000 * longint'(i) + 1292 * longint'(CURVE_TOP))
                            / (2584 * longint'(CURVE_TOP)));
            end else begin
                lhs = t_wide'(1);
                for (int n = 0; n < 5; n++) begin
                    lhs = lhs * t_wide'(510);
                end
                for (int n = 0; n < 12; n++) begin
                    lhs = lhs * t_wide'(1000 * i + 55 * CURVE_TOP);
                end
                while (code < 255 && lhs >= rhs[code + 1]) begin
                    code++;
                end
            end
            lin_curve[i] = 8'(code);
        end
    endtask

    // a source byte lands on every 2^(index bits - 8)-th curve entry
    function automatic logic [7:0] linearise(input logic [7:0] b);
        return lin_curve[int'(b) << (CURVE_INDEX_BITS - 8)];
    endfunction

    // expected texel under the current register copies; 0 when nothing comes back
    function automatic logic predict_texel(input t_pix px, output t_pix res);
        logic [2:0]  nch;
        logic [31:0] luma;
        int          idx;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        res = '0;
        nch = cfg_src;
        if (nch == 3'd0) nch = 3'd1;
        if (nch > 3'd4) nch = 3'd4;
        case (cfg_layout)
            LAYOUT_ONE: begin
                if (nch >= 3'd3) begin
                    luma = 32'(W_RED) * 32'(px[0]) + 32'(W_GREEN) * 32'(px[1])
                         + 32'(W_BLUE) * 32'(px[2]);
                    if (cfg_srgb) begin
                        idx = int'((luma + (32'd1 << (LUMA_SHIFT - 1))) >> LUMA_SHIFT);
                        if (idx > CURVE_TOP) idx = CURVE_TOP;
                        res[0] = lin_curve[idx];
                    end else begin
                        res[0] = 8'((luma + 32'd32768) >> 16);
                    end
                end else begin
                    res[0] = cfg_srgb ? linearise(px[0]) : px[0];
                end
            end
            LAYOUT_TWO: begin
                res[0] = px[0];
                res[1] = (nch >= 3'd2) ? px[1] : px[0];
            end
            LAYOUT_FOUR: begin
                r = px[0];
                g = (nch >= 3'd2) ? px[1] : px[0];
                b = (nch >= 3'd3) ? px[2] : px[0];
                res[3] = (nch >= 3'd4) ? px[3] : 8'hff;
                if (cfg_srgb) begin
                    r = linearise(r);
                    g = linearise(g);
                    b = linearise(b);
                end else if (nch == 3'd2) begin
                    b = 8'h00;
                end
                res[0] = r;
                res[1] = g;
                res[2] = b;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // bytes biased a little towards the two extremes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 15))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // hold start low until every expected texel is back, then let the pipe settle
    task automatic drain_pipe();
        start <= 1'b0;
        do @(posedge i_clk); while (want_texels.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no lowering in between
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    // one request, after an optional idle burst; start stays high on return
    task automatic send_texel(input t_row row, input int idle_pct);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_in_c0 <= row.px[0];
        i_in_c1 <= row.px[1];
        i_in_c2 <= row.px[2];
        i_in_c3 <= row.px[3];
        cur_req <= row;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // everything the block takes or gives is seen here, at the clock edge
    always @(posedge i_clk) begin
        t_pix got;
        t_pix want;
        t_pix pred;
        logic seen;
        seen = 1'b0;
        if (i_rst_n) begin
            // register write: keep the copies in step, masked to the field widths
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                seen = 1'b1;
                case (i_cfg_index)
                    CFG_SRC_CHANNELS: cfg_src    = i_cfg_data;
                    CFG_DST_LAYOUT:   cfg_layout = i_cfg_data[1:0];
                    CFG_SRGB_SOURCE:  cfg_srgb   = i_cfg_data[0];
                    default: ;
                endcase
            end
            // request taken: queue the typed-in texel or the predicted one
            if (start && busy === 1'b0) begin
                seen = 1'b1;
                if (cur_req.typed) begin
                    if (cur_req.has_res) want_texels.push_back(cur_req.want);
                end else if (predict_texel({i_in_c3, i_in_c2, i_in_c1, i_in_c0}, pred)) begin
                    want_texels.push_back(pred);
                end
            end
            // result strobe: compare channel by channel against the oldest expectation
            if (o_valid === 1'b1) begin
                seen = 1'b1;
                got = {o_out_c3, o_out_c2, o_out_c1, o_out_c0};
                if (want_texels.size() == 0) begin
                    $error("result %h with no request pending", got);
                    n_fail++;
                end else begin
                    want = want_texels.pop_front();
                    for (int j = 0; j < 4; j++) begin
                        if (got[j] !== want[j]) begin
                            $error("out_c%0d: expected %h, actual %h", j, want[j], got[j]);
                            n_fail++;
                        end
                    end
                end
            end
            // watchdog on cycles where nothing moves
            stall_cnt = seen ? 0 : stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int   ph;
        int   len;
        int   idle_pct;
        int   n_sent;
        t_row row;
        build_lin_curve();

        // single reset at the start, released on a clock edge
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: rewrite registers only where a row asks for other settings
        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].nsrc != cfg_src || dir_rows[r].layout != cfg_layout
                    || dir_rows[r].srgb != cfg_srgb) begin
                drain_pipe();
                write_reg(CFG_SRC_CHANNELS, dir_rows[r].nsrc);
                write_reg(CFG_DST_LAYOUT, {1'b0, dir_rows[r].layout});
                write_reg(CFG_SRGB_SOURCE, {2'b00, dir_rows[r].srgb});
                i_cfg_valid <= 1'b0;
            end
            send_texel(dir_rows[r], 20);
        end

        // random phases: first every in-range setting in turn, then anything the
        // register widths allow, raw data masked by the block
        ph     = 0;
        n_sent = 0;
        row    = '0;
        while (n_sent < N_ITEMS) begin
            drain_pipe();
            if (ph < 24) begin
                write_reg(CFG_SRC_CHANNELS, 3'(1 + ph % 4));
                write_reg(CFG_DST_LAYOUT, 3'((ph / 4) % 3));
                write_reg(CFG_SRGB_SOURCE, 3'(ph / 12));
            end else begin
                write_reg(CFG_SRC_CHANNELS, 3'($urandom_range(0, 7)));
                write_reg(CFG_DST_LAYOUT, 3'($urandom_range(0, 7)));
                write_reg(CFG_SRGB_SOURCE, 3'($urandom_range(0, 7)));
            end
            if (ph == 0 || $urandom_range(0, 3) == 0) begin
                write_reg(CFG_UNUSED, 3'($urandom_range(0, 7)));
            end
            i_cfg_valid <= 1'b0;

            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 50;
            endcase
            // closing stretch runs flat out
            if (n_sent > N_ITEMS - 300) idle_pct = 0;

            len = $urandom_range(20, 60);
            for (int k = 0; k < len; k++) begin
                // mid-phase pause until every texel in flight has come back
                if (ph == 3 && k == len / 2) drain_pipe();
                for (int j = 0; j < 4; j++) row.px[j] = rand_byte();
                send_texel(row, idle_pct);
                n_sent++;
            end
            ph++;
        end

        drain_pipe();
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
